@@ design/sce_pkg.sv @@
// Shared constants, codes and the scan-code translation tables for the
// scan-code line editor. No dependencies; the interfaces and the core import it.
package sce_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int TAB_SPACES = 4;
  localparam int TABLE_SIZE = 59;

  localparam int OP_W      = 2;
  localparam int CODE_W    = 8;
  localparam int ADDR_W    = $clog2(LINE_DEPTH);
  localparam int KIND_W    = 3;
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = ADDR_W + 1;
  localparam int CNT_W     = $clog2(TAB_SPACES + 1);
  localparam int TBL_IDX_W = $clog2(TABLE_SIZE);

  localparam logic [ADDR_W-1:0] FULL_LEVEL = ADDR_W'(LINE_DEPTH - 1);
  localparam logic [LEN_W-1:0]  LEN_FULL   = LEN_W'(LINE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_SCAN    = 2'd0,
    OP_LEN     = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 3'd0,
    KIND_ECHO  = 3'd1,
    KIND_ERASE = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  localparam logic [CODE_W-1:0] CODE_CAPS       = 8'h3A;
  localparam logic [CODE_W-1:0] CODE_LSHIFT     = 8'h2A;
  localparam logic [CODE_W-1:0] CODE_RSHIFT     = 8'h36;
  localparam logic [CODE_W-1:0] CODE_LSHIFT_REL = 8'hAA;
  localparam logic [CODE_W-1:0] CODE_RSHIFT_REL = 8'hB6;
  localparam logic [CODE_W-1:0] CODE_CTRL       = 8'h1D;
  localparam logic [CODE_W-1:0] CODE_CTRL_REL   = 8'h9D;
  localparam logic [CODE_W-1:0] CODE_ALT        = 8'h38;
  localparam logic [CODE_W-1:0] CODE_ALT_REL    = 8'hB8;
  localparam logic [CODE_W-1:0] CODE_BKSP       = 8'h0E;
  localparam logic [CODE_W-1:0] CODE_TAB        = 8'h0F;
  localparam logic [CODE_W-1:0] CODE_KEY_L      = 8'h26;
  localparam logic [CODE_W-1:0] CODE_ENTER      = 8'h1C;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CASE    = 8'h20;

  // Unshifted and shifted key maps; caps lock only flips the case of letters.
  localparam logic [CHAR_W-1:0] PLAIN_MAP [TABLE_SIZE] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  localparam logic [CHAR_W-1:0] SHIFT_MAP [TABLE_SIZE] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [TBL_IDX_W-1:0] idx,
                                                 input logic shift,
                                                 input logic caps);
    logic [CHAR_W-1:0] c;
    logic              letter;
    c = '0;
    if (int'(idx) < TABLE_SIZE) begin
      c = shift ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
    end
    letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    if (caps && letter) begin
      c = c ^ CHAR_CASE;
    end
    return c;
  endfunction

endpackage

@@ design/sce_if.sv @@
// Valid/ready channel interfaces for the scan-code line editor: the input
// item channel and the result channel. Depends on sce_pkg for field widths.
interface sce_in_if;
  import sce_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CODE_W-1:0] scan_byte;
  logic [ADDR_W-1:0] read_pos;

  modport source (output valid, op, scan_byte, read_pos, input ready);
  modport sink   (input valid, op, scan_byte, read_pos, output ready);
endinterface

interface sce_out_if;
  import sce_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_out;
  logic              line_ready;
  logic [LEN_W-1:0]  line_length;
  logic              last;

  modport source (output valid, kind, char_out, line_ready, line_length, last, input ready);
  modport sink   (input valid, kind, char_out, line_ready, line_length, last, output ready);
endinterface

@@ design/scan_code_line_editor_core.sv @@
// Scan-code line editor core: keyboard scan codes in, echo/erase/clear/read
// results out, with the typed line held in a 128 x 8 synchronous memory.
// Depends on sce_pkg and the channel interfaces in sce_if.sv.
//
// Usage: in_ch carries one item per transfer (op, scan_byte, read_pos).
// Every item produces one to four results on out_ch; the final one has last
// set, and all of them carry the line_ready flag and line_length as they
// stand after the item. A tab produces four echo results, every other item
// one. Results pass the job stage and then the result register to out_ch.
// Throughput is one result per cycle while out_ch is ready: a one-result item
// can enter as the last result of the item before it is sent, and a tab holds
// the input until its fourth result is sent. The rate is set by the single
// result register and the single write port of the line memory, which is
// written as echo results leave. A byte read issues its memory read at the
// input transfer; a write to the same entry in that cycle is forwarded. Reset
// clears the modifiers, the fill count and the ready flag; the line memory is
// not cleared and needs no sweep. While out_ch is stalled, results wait in
// the output register and the input stalls once the job stage is full.
module scan_code_line_editor_core (
  input logic     clk,
  input logic     rst_n,
  sce_in_if.sink  in_ch,
  sce_out_if.source out_ch
);
  import sce_pkg::*;

  // Editor state.
  logic              caps_r, caps_nxt;
  logic              shift_r, shift_nxt;
  logic              ctrl_r, ctrl_nxt;
  logic              alt_r, alt_nxt;
  logic              enter_r, enter_nxt;
  logic [ADDR_W-1:0] fill_r, fill_nxt;

  // Decoded item.
  kind_t             d_kind;
  logic [CHAR_W-1:0] d_chr;
  logic [CNT_W-1:0]  d_cnt;
  logic [CNT_W-1:0]  d_wr;
  logic              d_use_rd;
  logic [LEN_W-1:0]  d_len;
  logic [LEN_W-1:0]  cur_len;
  logic [ADDR_W-1:0] room;
  logic [CNT_W-1:0]  tab_stores;
  logic              has_room;

  // Job stage: the item whose results are being sent.
  logic              s_vld_r;
  kind_t             s_kind_r;
  logic [CHAR_W-1:0] s_chr_r;
  logic              s_use_rd_r;
  logic [CNT_W-1:0]  s_cnt_r;
  logic [CNT_W-1:0]  s_wr_left_r;
  logic [ADDR_W-1:0] s_wr_addr_r;
  logic              s_ready_r;
  logic [LEN_W-1:0]  s_len_r;

  // Line memory and its read path.
  logic [CHAR_W-1:0] mem [LINE_DEPTH];
  logic [CHAR_W-1:0] rdata_r;
  logic              fwd_hit_r;
  logic [CHAR_W-1:0] fwd_data_r;
  logic              we;
  logic              re;
  logic [CHAR_W-1:0] emit_chr;

  // Result register.
  logic              out_vld_r;
  kind_t             out_kind_r;
  logic [CHAR_W-1:0] out_chr_r;
  logic              out_ready_flag_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;

  logic              in_fire;
  logic              s_emit;
  logic              s_done;

  assign s_emit      = s_vld_r && (!out_vld_r || out_ch.ready);
  assign s_done      = s_emit && (s_cnt_r == CNT_W'(1));
  assign in_ch.ready = !s_vld_r || s_done;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign we = s_emit && (s_wr_left_r != '0);
  assign re = in_fire && (op_t'(in_ch.op) == OP_READ);

  always_comb begin
    caps_nxt  = caps_r;
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    enter_nxt = enter_r;
    fill_nxt  = fill_r;
    d_kind    = KIND_NONE;
    d_chr     = '0;
    d_cnt     = CNT_W'(1);
    d_wr      = '0;
    d_use_rd  = 1'b0;
    has_room  = (fill_r != FULL_LEVEL);
    room      = FULL_LEVEL - fill_r;
    tab_stores = (room < ADDR_W'(TAB_SPACES)) ? CNT_W'(room) : CNT_W'(TAB_SPACES);
    cur_len   = has_room ? LEN_W'(fill_r) : LEN_FULL;

    unique case (op_t'(in_ch.op))
      OP_SCAN: begin
        unique case (in_ch.scan_byte) inside
          CODE_CAPS:                        caps_nxt  = ~caps_r;
          CODE_LSHIFT, CODE_RSHIFT:         shift_nxt = 1'b1;
          CODE_LSHIFT_REL, CODE_RSHIFT_REL: shift_nxt = 1'b0;
          CODE_CTRL:                        ctrl_nxt  = 1'b1;
          CODE_CTRL_REL:                    ctrl_nxt  = 1'b0;
          CODE_ALT:                         alt_nxt   = 1'b1;
          CODE_ALT_REL:                     alt_nxt   = 1'b0;
          CODE_BKSP: begin
            // A full line keeps its length until it is released.
            if (fill_r != '0) begin
              d_kind = KIND_ERASE;
              if (has_room) begin
                fill_nxt = fill_r - ADDR_W'(1);
              end
            end
          end
          CODE_TAB: begin
            d_kind   = KIND_ECHO;
            d_chr    = CHAR_SPACE;
            d_cnt    = CNT_W'(TAB_SPACES);
            d_wr     = tab_stores;
            fill_nxt = fill_r + ADDR_W'(tab_stores);
          end
          default: begin
            if (!alt_r && (in_ch.scan_byte < CODE_W'(TABLE_SIZE))) begin
              if (ctrl_r) begin
                if (in_ch.scan_byte == CODE_KEY_L) begin
                  d_kind = KIND_CLEAR;
                end
              end else begin
                d_kind = KIND_ECHO;
                d_chr  = ascii_of(in_ch.scan_byte[TBL_IDX_W-1:0], shift_r, caps_r);
                if (has_room) begin
                  d_wr     = CNT_W'(1);
                  fill_nxt = fill_r + ADDR_W'(1);
                end
              end
            end
          end
        endcase
        if (in_ch.scan_byte == CODE_ENTER) begin
          enter_nxt = 1'b1;
        end
      end
      OP_LEN: begin
      end
      OP_READ: begin
        d_kind = KIND_READ;
        if (LEN_W'(in_ch.read_pos) < cur_len) begin
          // The last slot of a full line reads as the appended newline.
          if (!has_room && (in_ch.read_pos == FULL_LEVEL)) begin
            d_chr = CHAR_NEWLINE;
          end else begin
            d_use_rd = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        fill_nxt  = '0;
        enter_nxt = 1'b0;
      end
    endcase

    d_len = (fill_nxt == FULL_LEVEL) ? LEN_FULL : LEN_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r  <= 1'b0;
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
      enter_r <= 1'b0;
      fill_r  <= '0;
    end else if (in_fire) begin
      caps_r  <= caps_nxt;
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      alt_r   <= alt_nxt;
      enter_r <= enter_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Job stage: loaded on an input transfer, counts down one result per send.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_fire) begin
      s_vld_r <= 1'b1;
    end else if (s_done) begin
      s_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_kind_r    <= d_kind;
      s_chr_r     <= d_chr;
      s_use_rd_r  <= d_use_rd;
      s_cnt_r     <= d_cnt;
      s_wr_left_r <= d_wr;
      s_wr_addr_r <= fill_r;
      s_ready_r   <= enter_nxt;
      s_len_r     <= d_len;
    end else if (s_emit) begin
      s_cnt_r <= s_cnt_r - CNT_W'(1);
      if (s_wr_left_r != '0) begin
        s_wr_left_r <= s_wr_left_r - CNT_W'(1);
        s_wr_addr_r <= s_wr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[s_wr_addr_r] <= s_chr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[in_ch.read_pos];
    end
  end

  // The previous item's last store can land in the same cycle as this read.
  always_ff @(posedge clk) begin
    if (re) begin
      fwd_hit_r  <= we && (s_wr_addr_r == in_ch.read_pos);
      fwd_data_r <= s_chr_r;
    end
  end

  assign emit_chr = !s_use_rd_r ? s_chr_r : (fwd_hit_r ? fwd_data_r : rdata_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s_emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_emit) begin
      out_kind_r       <= s_kind_r;
      out_chr_r        <= emit_chr;
      out_ready_flag_r <= s_ready_r;
      out_len_r        <= s_len_r;
      out_last_r       <= (s_cnt_r == CNT_W'(1));
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.char_out    = out_chr_r;
  assign out_ch.line_ready  = out_ready_flag_r;
  assign out_ch.line_length = out_len_r;
  assign out_ch.last        = out_last_r;

`ifndef SYNTHESIS
  // A new item may only enter once the previous one has at most its last store left to make.
  a_no_pending_store: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s_vld_r) |-> (s_wr_left_r <= CNT_W'(1)))
    else $error("item accepted while the job stage still had stores pending");

  a_stores_within_results: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld_r |-> ((s_cnt_r != '0) && (s_wr_left_r <= s_cnt_r)))
    else $error("job stage store count exceeds its remaining results");

  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == KIND_READ)) |-> out_last_r)
    else $error("byte read result not marked as last");

  a_last_frees_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s_done && !in_fire) |=> !s_vld_r)
    else $error("job stage still busy after its last result was sent");
`endif

endmodule

@@ dv/sce_line_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the scan-code line editor: watches both channels, predicts the
// results of every input transfer and compares them. Depends on sce_pkg and sce_if.sv.
module sce_line_checker (
  input  logic      clk,
  input  logic      rst_n,
  sce_in_if         in_mon,
  sce_out_if        out_mon,
  output int        fail_count,
  output int        pending,
  output int        results_checked
);
  import sce_pkg::*;

  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  localparam logic [CHAR_W-1:0] UNSHIFTED [TABLE_SIZE] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  localparam logic [CHAR_W-1:0] SHIFTED [TABLE_SIZE] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  typedef struct {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic              ready;
    logic [LEN_W-1:0]  len;
    logic              last;
  } line_result_t;

  logic              caps_on, shift_on, ctrl_on, alt_on;
  logic              enter_seen, store_en;
  logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
  int                fill;
  int                errors;
  int                checked;

  line_result_t      expected_q [$];
  kind_t             item_kinds [$];
  logic [CHAR_W-1:0] item_chars [$];

  function automatic logic [LEN_W-1:0] line_len();
    return (fill >= LINE_DEPTH - 1) ? LEN_FULL : LEN_W'(fill);
  endfunction

  function automatic void add_result(kind_t k, logic [CHAR_W-1:0] c);
    item_kinds.push_back(k);
    item_chars.push_back(c);
  endfunction

  function automatic void keep_char(logic [CHAR_W-1:0] c);
    if (store_en && fill < LINE_DEPTH - 1) begin
      line_mem[ADDR_W'(fill)] = c;
      fill++;
    end
    if (fill >= LINE_DEPTH - 1) store_en = 1'b0;
  endfunction

  // Caps lock swaps the case of letters only, on top of the shift state.
  function automatic logic [CHAR_W-1:0] key_char(logic [TBL_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = shift_on ? SHIFTED[idx] : UNSHIFTED[idx];
    if (caps_on && (((c | CASE_BIT) >= 8'h61) && ((c | CASE_BIT) <= 8'h7A)))
      c = c ^ CASE_BIT;
    return c;
  endfunction

  function automatic void decode_scan(logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      CODE_CAPS:                        caps_on = !caps_on;
      CODE_LSHIFT, CODE_RSHIFT:         shift_on = 1'b1;
      CODE_LSHIFT_REL, CODE_RSHIFT_REL: shift_on = 1'b0;
      CODE_CTRL:                        ctrl_on = 1'b1;
      CODE_CTRL_REL:                    ctrl_on = 1'b0;
      CODE_ALT:                         alt_on = 1'b1;
      CODE_ALT_REL:                     alt_on = 1'b0;
      CODE_BKSP: begin
        // A full line still shows the erase but keeps its contents.
        if (fill > 0) begin
          add_result(KIND_ERASE, '0);
          if (store_en) fill--;
        end
      end
      CODE_TAB: begin
        repeat (TAB_SPACES) begin
          add_result(KIND_ECHO, CHAR_SPACE);
          keep_char(CHAR_SPACE);
        end
      end
      default: begin
        if (!alt_on && int'(code) < TABLE_SIZE) begin
          if (ctrl_on) begin
            if (code == CODE_KEY_L) add_result(KIND_CLEAR, '0);
          end else begin
            c = key_char(code[TBL_IDX_W-1:0]);
            add_result(KIND_ECHO, c);
            keep_char(c);
          end
        end
      end
    endcase
    if (code == CODE_ENTER) enter_seen = 1'b1;
    if (fill >= LINE_DEPTH - 1) store_en = 1'b0;
  endfunction

  function automatic void predict_item(op_t op, logic [CODE_W-1:0] code,
                                       logic [ADDR_W-1:0] pos);
    line_result_t r;
    logic [CHAR_W-1:0] b;
    item_kinds.delete();
    item_chars.delete();
    case (op)
      OP_SCAN: decode_scan(code);
      OP_READ: begin
        b = '0;
        if (LEN_W'(pos) < line_len()) begin
          if (line_len() == LEN_FULL && int'(pos) == LINE_DEPTH - 1) b = CHAR_NEWLINE;
          else b = line_mem[pos];
        end
        add_result(KIND_READ, b);
      end
      OP_RELEASE: begin
        fill = 0;
        store_en = 1'b1;
        enter_seen = 1'b0;
      end
      default: ;
    endcase
    if (item_kinds.size() == 0) add_result(KIND_NONE, '0);
    foreach (item_kinds[k]) begin
      r.kind  = item_kinds[k];
      r.ch    = item_chars[k];
      r.ready = enter_seen;
      r.len   = line_len();
      r.last  = (k == item_kinds.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  function automatic void check_result();
    line_result_t e;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result kind=%0d char=%02h ready=%0b len=%0d last=%0b",
               $time, out_mon.kind, out_mon.char_out, out_mon.line_ready,
               out_mon.line_length, out_mon.last);
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (out_mon.kind !== e.kind || out_mon.char_out !== e.ch ||
        out_mon.line_ready !== e.ready || out_mon.line_length !== e.len ||
        out_mon.last !== e.last) begin
      errors++;
      $display("%0t: mismatch expected kind=%0d char=%02h ready=%0b len=%0d last=%0b",
               $time, e.kind, e.ch, e.ready, e.len, e.last);
      $display("%0t:          actual   kind=%0d char=%02h ready=%0b len=%0d last=%0b",
               $time, out_mon.kind, out_mon.char_out, out_mon.line_ready,
               out_mon.line_length, out_mon.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      caps_on    = 1'b0;
      shift_on   = 1'b0;
      ctrl_on    = 1'b0;
      alt_on     = 1'b0;
      enter_seen = 1'b0;
      store_en   = 1'b1;
      fill       = 0;
      expected_q.delete();
    end else begin
      // Results trail their input through the job stage and the result register, so the order here is free.
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        predict_item(op_t'(in_mon.op), in_mon.scan_byte, in_mon.read_pos);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
        check_result();
    end
    fail_count      <= errors;
    pending         <= expected_q.size();
    results_checked <= checked;
  end

endmodule

@@ dv/tb_scan_code_line_editor_core.sv @@
`timescale 1ns / 100ps
// Top of the line editor testbench: clock, reset, stimulus and verdict.
// Depends on sce_pkg, sce_if.sv, the core and the checker in sce_line_checker.sv.
module tb_scan_code_line_editor_core;
  import sce_pkg::*;

  localparam int ITEM_TARGET  = 370;
  localparam int IDLE_PCT     = 19;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet;
  int   items_sent;
  int   directed_items;
  int   cycle_count;
  int   fail_count, pending, results_checked;

  sce_in_if  in_ch ();
  sce_out_if out_ch ();

  scan_code_line_editor_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sce_line_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Holds one item on the input until its transfer; valid stays high if the
  // next item follows without a gap.
  task automatic send_item(input op_t op, input logic [CODE_W-1:0] code,
                           input logic [ADDR_W-1:0] pos);
    quiet = (items_sent >= 150 && items_sent < 240);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.scan_byte <= code;
    in_ch.read_pos  <= pos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic press(input logic [CODE_W-1:0] code);
    send_item(OP_SCAN, code, ADDR_W'($urandom_range(LINE_DEPTH - 1)));
  endtask

  task automatic read_at(input int pos);
    send_item(OP_READ, CODE_W'($urandom_range(255)), ADDR_W'(pos));
  endtask

  function automatic logic [CODE_W-1:0] pick_key(input int tab_pct);
    int r;
    if ($urandom_range(99) < tab_pct) return CODE_TAB;
    r = $urandom_range(99);
    if (r < 8)  return CODE_BKSP;
    if (r < 13) return CODE_ENTER;
    if (r < 21) begin
      case ($urandom_range(3))
        0:       return CODE_LSHIFT;
        1:       return CODE_RSHIFT;
        2:       return CODE_LSHIFT_REL;
        default: return CODE_RSHIFT_REL;
      endcase
    end
    if (r < 24) return CODE_CAPS;
    if (r < 36) return CODE_W'($urandom_range(255));
    return CODE_W'($urandom_range(TABLE_SIZE - 1));
  endfunction

  // Ctrl or alt held over one or two keys, then let go.
  task automatic send_chord();
    bit use_ctrl;
    use_ctrl = 1'($urandom_range(1));
    press(use_ctrl ? CODE_CTRL : CODE_ALT);
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(1)) press(CODE_KEY_L);
      else press(pick_key(10));
    end
    press(use_ctrl ? CODE_CTRL_REL : CODE_ALT_REL);
  endtask

  // One typed line: keys, a length query, a few reads, usually a release.
  // Long lines are tab heavy so that they run into the full-line limit.
  task automatic type_line(input bit long_line, input int goal);
    int n_keys;
    int tab_pct;
    n_keys  = long_line ? $urandom_range(60, 75) : $urandom_range(3, 20);
    tab_pct = long_line ? 45 : 6;
    for (int i = 0; i < n_keys && items_sent < goal; i++) begin
      if ($urandom_range(99) < 8) send_chord();
      else press(pick_key(tab_pct));
    end
    send_item(OP_LEN, CODE_W'($urandom_range(255)), ADDR_W'($urandom_range(LINE_DEPTH - 1)));
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(99) < 25) read_at($urandom_range(LINE_DEPTH - 1));
      else if (long_line) read_at($urandom_range(LINE_DEPTH - 8, LINE_DEPTH - 1));
      else read_at($urandom_range(24));
    end
    if ($urandom_range(99) < 85)
      send_item(OP_RELEASE, CODE_W'($urandom_range(255)),
                ADDR_W'($urandom_range(LINE_DEPTH - 1)));
  endtask

  initial begin
    int goal;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_SCAN;
    in_ch.scan_byte = '0;
    in_ch.read_pos  = '0;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty line, case and modifier handling, dead codes, chords.
    send_item(OP_LEN, 8'hFF, '1);
    press(CODE_BKSP);
    press(8'h1E);
    press(CODE_CAPS);
    press(8'h1E);
    press(CODE_LSHIFT);
    press(8'h02);
    press(8'h1E);
    press(CODE_LSHIFT_REL);
    press(8'h00);
    press(8'h3B);
    press(8'hFF);
    press(CODE_TAB);
    press(CODE_CTRL);
    press(CODE_KEY_L);
    press(CODE_CTRL_REL);
    press(CODE_ALT);
    press(CODE_ENTER);
    press(CODE_ALT_REL);
    press(CODE_RSHIFT);
    press(8'h10);
    press(CODE_RSHIFT_REL);
    press(CODE_BKSP);
    read_at(LINE_DEPTH - 1);
    send_item(OP_RELEASE, '0, '0);
    directed_items = items_sent;

    goal = ITEM_TARGET;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 4))
          send_item(op_t'($urandom_range(3)), CODE_W'($urandom_range(255)),
                    ADDR_W'($urandom_range(LINE_DEPTH - 1)));
      end else begin
        type_line($urandom_range(99) < 25, goal);
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input items (%0d directed) and checked %0d results,",
             items_sent, directed_items, results_checked);
    $display("covering modifiers, caps lock, tabs, erase, full lines and byte reads.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
